### design/cc20_pkg.sv
package cc20_pkg;

    // Default number of double rounds (ChaCha20).
    localparam int DOUBLE_ROUNDS_DEF = 10;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_0_63     = 3'd0,
        CFG_KEY_64_127   = 3'd1,
        CFG_KEY_128_191  = 3'd2,
        CFG_KEY_192_255  = 3'd3,
        CFG_NONCE_0_63   = 3'd4,
        CFG_NONCE_64_95  = 3'd5,
        CFG_START_CTR    = 3'd6
    } cfg_reg_t;

    // The four "expand 32-byte k" constant words.
    localparam logic [31:0] SIGMA_0 = 32'h6170_7865;
    localparam logic [31:0] SIGMA_1 = 32'h3320_646e;
    localparam logic [31:0] SIGMA_2 = 32'h7962_2d32;
    localparam logic [31:0] SIGMA_3 = 32'h6b20_6574;

    // One input item.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_of_message;
        logic       last_of_message;
    } src_item_t;

    // One result item.
    typedef struct packed {
        logic [7:0] result_byte;
        logic       result_last;
    } result_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       accept;   // input transfer this cycle
        logic       load;     // load the working state from the block inputs
        logic       round;    // apply one line of four parallel quarter rounds
        logic [1:0] line;     // which line of the quarter round
        logic       diag;     // diagonal round when set, column round otherwise
        logic       addback;  // add the initial words back, advance the counter
        logic       emit;     // write one result into the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic gen_needed;     // the offered byte starts a new keystream block
        logic out_free;       // the output register can take a result
    } status_t;

    // Rotate left by a fixed amount.
    function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned n);
        return (v << n) | (v >> (32 - n));
    endfunction

endpackage

### design/cc20_datapath.sv
module cc20_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic [cc20_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cc20_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  cc20_pkg::src_item_t              src_item,
    input  cc20_pkg::cmd_t                   cmd,
    output cc20_pkg::status_t                status,
    input  logic                             res_ready,
    output logic                             res_valid,
    output cc20_pkg::result_item_t           res_item
);
    import cc20_pkg::*;

    logic [63:0] key_reg [4];
    logic [63:0] nonce_lo_reg;
    logic [31:0] nonce_hi_reg;
    logic [31:0] start_ctr_reg;

    logic [31:0] w_reg  [16];
    logic [31:0] w_next [16];
    logic [31:0] init_cur [16];

    logic [5:0]  pos_reg;
    logic [31:0] ctr_reg;
    logic [7:0]  held_data_reg;
    logic        held_last_reg;
    logic        res_valid_reg;
    result_item_t res_item_reg;

    logic [31:0] ctr_eff;
    logic [5:0]  pos_eff;
    logic [5:0]  pos_base;
    logic [7:0]  data_sel;
    logic        last_sel;
    logic [31:0] ks_word;
    logic [7:0]  ks_byte;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                key_reg[i] <= '0;
            end
            nonce_lo_reg  <= '0;
            nonce_hi_reg  <= '0;
            start_ctr_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_KEY_0_63:    key_reg[0]    <= cfg_data;
                CFG_KEY_64_127:  key_reg[1]    <= cfg_data;
                CFG_KEY_128_191: key_reg[2]    <= cfg_data;
                CFG_KEY_192_255: key_reg[3]    <= cfg_data;
                CFG_NONCE_0_63:  nonce_lo_reg  <= cfg_data;
                CFG_NONCE_64_95: nonce_hi_reg  <= cfg_data[31:0];
                CFG_START_CTR:   start_ctr_reg <= cfg_data[31:0];
                default:         ;
            endcase
        end
    end

    // Initial block words for the current block counter.
    always_comb
    begin
        init_cur[0] = SIGMA_0;
        init_cur[1] = SIGMA_1;
        init_cur[2] = SIGMA_2;
        init_cur[3] = SIGMA_3;
        for (int i = 0; i < 4; i++)
        begin
            init_cur[4 + 2 * i] = key_reg[i][31:0];
            init_cur[5 + 2 * i] = key_reg[i][63:32];
        end
        init_cur[12] = ctr_reg;
        init_cur[13] = nonce_lo_reg[31:0];
        init_cur[14] = nonce_lo_reg[63:32];
        init_cur[15] = nonce_hi_reg;
    end

    // A first byte restarts the position and reloads the counter.
    assign ctr_eff  = src_item.first_of_message ? start_ctr_reg : ctr_reg;
    assign pos_eff  = src_item.first_of_message ? 6'd0 : pos_reg;
    assign pos_base = cmd.accept ? pos_eff : pos_reg;
    assign data_sel = cmd.accept ? src_item.data_byte : held_data_reg;
    assign last_sel = cmd.accept ? src_item.last_of_message : held_last_reg;

    // Keystream byte selection, little-endian within each word.
    assign ks_word = w_reg[pos_base[5:2]];
    assign ks_byte = ks_word[{pos_base[1:0], 3'b000} +: 8];

    // Working state update: load, one quarter-round line on four lanes, or add-back.
    always_comb
    begin
        logic [1:0]  l;
        logic [3:0]  ia;
        logic [3:0]  ib;
        logic [3:0]  ic;
        logic [3:0]  id;
        logic [31:0] sum;
        l      = '0;
        ia     = '0;
        ib     = '0;
        ic     = '0;
        id     = '0;
        sum    = '0;
        w_next = w_reg;
        if (cmd.load)
        begin
            w_next     = init_cur;
            w_next[12] = ctr_eff;
        end
        else if (cmd.round)
        begin
            for (int lane = 0; lane < 4; lane++)
            begin
                l  = 2'(lane);
                ia = {2'b00, l};
                ib = {2'b01, l + {1'b0, cmd.diag}};
                ic = {2'b10, l + {cmd.diag, 1'b0}};
                id = {2'b11, l + {cmd.diag, cmd.diag}};
                case (cmd.line)
                    2'd0:
                    begin
                        sum        = w_reg[ia] + w_reg[ib];
                        w_next[ia] = sum;
                        w_next[id] = rotl32(w_reg[id] ^ sum, 16);
                    end
                    2'd1:
                    begin
                        sum        = w_reg[ic] + w_reg[id];
                        w_next[ic] = sum;
                        w_next[ib] = rotl32(w_reg[ib] ^ sum, 12);
                    end
                    2'd2:
                    begin
                        sum        = w_reg[ia] + w_reg[ib];
                        w_next[ia] = sum;
                        w_next[id] = rotl32(w_reg[id] ^ sum, 8);
                    end
                    default:
                    begin
                        sum        = w_reg[ic] + w_reg[id];
                        w_next[ic] = sum;
                        w_next[ib] = rotl32(w_reg[ib] ^ sum, 7);
                    end
                endcase
            end
        end
        else if (cmd.addback)
        begin
            for (int i = 0; i < 16; i++)
            begin
                w_next[i] = w_reg[i] + init_cur[i];
            end
        end
    end

    // Working state doubles as the keystream block once finished.
    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
    end

    // Held byte for results that wait on block generation or the output.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            held_data_reg <= src_item.data_byte;
            held_last_reg <= src_item.last_of_message;
        end
    end

    // Byte position and block counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            ctr_reg <= '0;
        end
        else
        begin
            if (cmd.emit)
            begin
                pos_reg <= pos_base + 6'd1;
            end
            else if (cmd.accept)
            begin
                pos_reg <= pos_eff;
            end
            if (cmd.accept && src_item.first_of_message)
            begin
                ctr_reg <= start_ctr_reg;
            end
            else if (cmd.addback)
            begin
                ctr_reg <= ctr_reg + 32'd1;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            res_item_reg.result_byte <= data_sel ^ ks_byte;
            res_item_reg.result_last <= last_sel;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    // Status toward the controller.
    assign status.gen_needed = src_item.first_of_message || (pos_reg == 6'd0);
    assign status.out_free   = !res_valid_reg || res_ready;

endmodule

### design/cc20_ctrl.sv
module cc20_ctrl #(
    parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              src_valid,
    output logic              src_ready,
    input  cc20_pkg::status_t status,
    output cc20_pkg::cmd_t    cmd
);
    import cc20_pkg::*;

    localparam int RND_W = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ROUND = 4'b0010,
        S_ADD   = 4'b0100,
        S_EMIT  = 4'b1000
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [2:0]       step_reg;
    logic [2:0]       step_next;
    logic [RND_W-1:0] round_reg;
    logic [RND_W-1:0] round_next;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        round_next = round_reg;
        cmd        = '0;
        src_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                src_ready  = 1'b1;
                cmd.accept = src_valid;
                if (src_valid)
                begin
                    if (status.gen_needed)
                    begin
                        cmd.load   = 1'b1;
                        step_next  = '0;
                        round_next = '0;
                        state_next = S_ROUND;
                    end
                    else if (status.out_free)
                    begin
                        cmd.emit = 1'b1;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_ROUND:
            begin
                cmd.round = 1'b1;
                cmd.line  = step_reg[1:0];
                cmd.diag  = step_reg[2];
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd7)
                begin
                    if (round_reg == RND_W'(DOUBLE_ROUNDS - 1))
                    begin
                        state_next = S_ADD;
                    end
                    else
                    begin
                        round_next = round_reg + 1'b1;
                    end
                end
            end
            S_ADD:
            begin
                cmd.addback = 1'b1;
                state_next  = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            round_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            round_reg <= round_next;
        end
    end

endmodule

### design/chacha20_stream_cipher_top.sv
// ChaCha20 byte-stream cipher: each input byte is XORed with the next keystream
// byte and returned with its last-of-message flag. Key, nonce and the start block
// counter are written through the configuration port (always ready); the user must
// write them only while no byte is in flight, as the block does not enforce it. A
// byte that continues the current 64-byte block is written into the output register
// in its transfer cycle when that register is free, and the next byte can then be
// taken in the following cycle. A byte at block position 0, or one that carries the
// first-of-message flag, makes a new block first: the single four-lane quarter-round
// unit applies one add-xor-rotate line per cycle, so after the transfer come the
// round lines, the add-back and the output step. The next byte is taken only after
// that result is written into the output register; a result that waits at the
// output stretches the output step. The output register lets a byte be taken while
// an earlier result waits.
module chacha20_stream_cipher_top #(
    parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [cc20_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cc20_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             src_valid,
    output logic                             src_ready,
    input  cc20_pkg::src_item_t              src_item,
    output logic                             res_valid,
    input  logic                             res_ready,
    output cc20_pkg::result_item_t           res_item
);
    import cc20_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    // Sequencer.
    cc20_ctrl #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Block state, quarter-round unit and output register.
    cc20_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .src_item  (src_item),
        .cmd       (cmd),
        .status    (status),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .res_item  (res_item)
    );

    // A transfer that starts a block holds off the next transfer.
    a_gen_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (src_valid && src_ready && status.gen_needed) |=> !src_ready)
        else $error("input taken during block generation");

    // A result is only written when the output register is free.
    a_emit_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!res_valid || res_ready))
        else $error("result overwrote a pending result");

    // After the add-back the pending byte is still owed, so no new transfer.
    a_addback_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.addback |=> !src_ready)
        else $error("input taken before the pending byte was delivered");

endmodule
